/* hw/rtl/dcrc_pkg.sv */
package dcrc_pkg;

	// CRC-16 polynomial and reset value shared by both registers
	localparam logic [15:0] CRC_POLY = 16'h8005;
	localparam logic [15:0] CRC_INIT = 16'h0000;

	// one input item after the input register
	typedef struct packed {
		logic [7:0]  data_byte;
		logic        last_byte;
		logic [15:0] reference_crc;
	} dcrc_item_t;

	// one result item
	typedef struct packed {
		logic [15:0] crc_reflected;
		logic [15:0] crc_plain;
		logic        crc_match;
	} dcrc_result_t;

	// advance a CRC register by one byte, MSB first
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] byte_in);
		logic [15:0] r;
		logic        fb;
		r = crc;
		for (int k = 0; k < 8; k++) begin
			fb = r[15] ^ byte_in[7 - k];
			r  = {r[14:0], 1'b0};
			if (fb) begin
				r = r ^ CRC_POLY;
			end
		end
		return r;
	endfunction

	// bit order reversal of a byte
	function automatic logic [7:0] rev8(input logic [7:0] v);
		logic [7:0] r;
		for (int k = 0; k < 8; k++) begin
			r[k] = v[7 - k];
		end
		return r;
	endfunction

	// bit order reversal of a 16-bit word
	function automatic logic [15:0] rev16(input logic [15:0] v);
		logic [15:0] r;
		for (int k = 0; k < 16; k++) begin
			r[k] = v[15 - k];
		end
		return r;
	endfunction

endpackage

/* hw/rtl/dcrc_engine.sv */
module dcrc_engine (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  dcrc_pkg::dcrc_item_t  in_item,
	output logic                  in_ready,
	output logic                  out_valid,
	output dcrc_pkg::dcrc_result_t out_result,
	input  logic                  out_ready
);

	logic [15:0]            plain_q;
	logic [15:0]            refl_q;
	logic [15:0]            plain_next;
	logic [15:0]            refl_next;
	logic [15:0]            refl_out;
	logic                   take;
	logic                   out_valid_q;
	dcrc_pkg::dcrc_result_t result_q;

	// both CRCs advanced by this byte
	assign plain_next = dcrc_pkg::crc_feed(plain_q, in_item.data_byte);
	assign refl_next  = dcrc_pkg::crc_feed(refl_q, dcrc_pkg::rev8(in_item.data_byte));
	assign refl_out   = dcrc_pkg::rev16(refl_next);

	// a non-last byte never needs the result slot
	assign in_ready = !in_item.last_byte || !out_valid_q || out_ready;
	assign take     = in_valid && in_ready;

	// running CRC registers, cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plain_q     <= dcrc_pkg::CRC_INIT;
			refl_q      <= dcrc_pkg::CRC_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (take && in_item.last_byte) begin
				plain_q     <= dcrc_pkg::CRC_INIT;
				refl_q      <= dcrc_pkg::CRC_INIT;
				out_valid_q <= 1'b1;
			end else begin
				if (take) begin
					plain_q <= plain_next;
					refl_q  <= refl_next;
				end
				if (out_ready) begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (take && in_item.last_byte) begin
			result_q.crc_plain     <= plain_next;
			result_q.crc_reflected <= refl_out;
			result_q.crc_match     <= (plain_next == in_item.reference_crc) ||
				(refl_out == in_item.reference_crc);
		end
	end

	assign out_valid  = out_valid_q;
	assign out_result = result_q;

	// registers restart from zero after a message
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		take && in_item.last_byte |=> plain_q == dcrc_pkg::CRC_INIT &&
			refl_q == dcrc_pkg::CRC_INIT)
		else $error("crc registers not cleared after last byte");

	// a last byte always produces a result
	a_result_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		take && in_item.last_byte |=> out_valid_q)
		else $error("no result after last byte");

	// a pending result blocks the next last byte
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready && in_item.last_byte |-> !take)
		else $error("pending result overwritten");

	// match flag agrees with the stored CRCs and the sampled reference
	a_match: assert property (@(posedge clk) disable iff (!arst_n)
		take && in_item.last_byte |=> result_q.crc_match ==
			((result_q.crc_plain == $past(in_item.reference_crc)) ||
			(result_q.crc_reflected == $past(in_item.reference_crc))))
		else $error("match flag inconsistent");

endmodule

/* hw/rtl/dual_crc16_check.sv */
// A byte enters the input register when it is accepted; a last byte's result is then
// written from there into the result register, where it waits to be taken.
// Throughput: one byte per cycle, set by the single-byte CRC update logic; a last
// byte waits in the input register while the previous result is still held.
// Reset (arst_n low, asynchronous) clears both CRC registers to zero and
// empties the input and result registers.
module dual_crc16_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // [7:0] data_byte, [23:8] reference_crc
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata   // [0] crc_match, [16:1] crc_plain,
	                                   // [32:17] crc_reflected, [39:33] zero
);

	logic                   valid_s1;
	dcrc_pkg::dcrc_item_t   item_s1;
	logic                   eng_ready;
	dcrc_pkg::dcrc_result_t result;

	assign s_axis_tready = !valid_s1 || eng_ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.data_byte     <= s_axis_tdata[7:0];
			item_s1.reference_crc <= s_axis_tdata[23:8];
			item_s1.last_byte     <= s_axis_tlast;
		end
	end

	dcrc_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (valid_s1),
		.in_item    (item_s1),
		.in_ready   (eng_ready),
		.out_valid  (m_axis_tvalid),
		.out_result (result),
		.out_ready  (m_axis_tready)
	);

	// pack result fields, crc_match in the lowest bit, zero padding on top
	assign m_axis_tdata = {7'b0, result.crc_reflected, result.crc_plain, result.crc_match};

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 300;
	localparam int RANDOM_BYTES = 1930;
	localparam int QUIET_FROM   = 1650;
	localparam int DRAIN_CYCLES = 10;

	// one row of the directed table
	typedef struct packed {
		logic [7:0]             data;
		logic                   last;
		logic [15:0]            chk;
		logic                   typed;
		dcrc_pkg::dcrc_result_t res;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;  // [7:0] data_byte, [23:8] reference_crc
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;  // [0] crc_match, [16:1] crc_plain, [32:17] crc_reflected

	// running CRC values of the message in flight, as the block should hold them
	logic [15:0] plain_acc;
	logic [15:0] refl_acc;

	// results still owed by the block, oldest first
	dcrc_pkg::dcrc_result_t owed_results[$];

	int  err_count;
	int  cycle_count;
	int  results_seen;
	int  matches_seen;
	int  msgs_sent;
	int  bytes_sent;
	bit  quiet;
	bit  hold_req;

	dual_crc16_check dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// directed items: extremes, ignored reference on inner bytes, the standard check string
	dir_row_t dir_rows [0:17] = '{
		'{8'h00, 1'b1, 16'h0000, 1'b1, '{16'h0000, 16'h0000, 1'b1}},
		'{8'h00, 1'b1, 16'hFFFF, 1'b1, '{16'h0000, 16'h0000, 1'b0}},
		'{8'hFF, 1'b1, 16'hFFFF, 1'b0, '0},
		'{8'h80, 1'b1, 16'h0001, 1'b0, '0},
		'{8'h01, 1'b1, 16'h8000, 1'b0, '0},
		'{8'h00, 1'b0, 16'hFFFF, 1'b0, '0},
		'{8'h00, 1'b1, 16'h0000, 1'b1, '{16'h0000, 16'h0000, 1'b1}},
		'{8'h31, 1'b0, 16'h5555, 1'b0, '0},
		'{8'h32, 1'b0, 16'hAAAA, 1'b0, '0},
		'{8'h33, 1'b0, 16'hBB3D, 1'b0, '0},
		'{8'h34, 1'b0, 16'hFEE8, 1'b0, '0},
		'{8'h35, 1'b0, 16'h0000, 1'b0, '0},
		'{8'h36, 1'b0, 16'hFFFF, 1'b0, '0},
		'{8'h37, 1'b0, 16'h1234, 1'b0, '0},
		'{8'h38, 1'b0, 16'h8001, 1'b0, '0},
		'{8'h39, 1'b1, 16'hBB3D, 1'b1, '{16'hBB3D, 16'hFEE8, 1'b1}},
		'{8'hA5, 1'b0, 16'hFEE8, 1'b0, '0},
		'{8'h5A, 1'b1, 16'hFFFF, 1'b0, '0}
	};

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// one CRC-16 step, poly 0x8005, byte entered MSB first
	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		int          k;
		c = crc ^ {b, 8'h00};
		for (k = 0; k < 8; k++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ dcrc_pkg::CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	// reverse the low 'width' bits of v
	function automatic logic [15:0] flip_low(input logic [15:0] v, input int width);
		logic [15:0] out;
		int          k;
		out = '0;
		for (k = 0; k < width; k++) begin
			out[k] = v[width - 1 - k];
		end
		return out;
	endfunction

	// fold one accepted byte into the running CRCs; a last byte yields a result
	task automatic absorb_byte(input logic [7:0] data, input logic last, input logic [15:0] chk,
			output logic done, output dcrc_pkg::dcrc_result_t res);
		plain_acc = crc_step(plain_acc, data);
		refl_acc  = crc_step(refl_acc, flip_low({8'h00, data}, 8));
		done      = last;
		res       = '0;
		if (last) begin
			res.crc_plain     = plain_acc;
			res.crc_reflected = flip_low(refl_acc, 16);
			res.crc_match     = (res.crc_plain == chk) || (res.crc_reflected == chk);
			plain_acc         = dcrc_pkg::CRC_INIT;
			refl_acc          = dcrc_pkg::CRC_INIT;
		end
	endtask

	// offer one item, wait for its handshake, then record what it should produce
	task automatic send_item(input logic [7:0] data, input logic last, input logic [15:0] chk,
			input logic typed, input dcrc_pkg::dcrc_result_t typed_res);
		logic                   done;
		dcrc_pkg::dcrc_result_t pred;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(0, 4)) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {chk, data};
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		absorb_byte(data, last, chk, done, pred);
		bytes_sent++;
		if (done) begin
			msgs_sent++;
			owed_results.push_back(typed ? typed_res : pred);
		end
	endtask

	// result side: random stall bursts, one long hold-off on request, none when quiet
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(0, 4)) @(negedge clk);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// compare each accepted result with the oldest one owed
	always @(posedge clk) begin
		dcrc_pkg::dcrc_result_t got;
		dcrc_pkg::dcrc_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[32:0];
			results_seen++;
			if (got.crc_match) begin
				matches_seen++;
			end
			if (owed_results.size() == 0) begin
				err_count++;
				$display("%0t: unexpected result, expected none, got %h", $time, got);
			end else begin
				want = owed_results.pop_front();
				if (got.crc_match !== want.crc_match) begin
					err_count++;
					$display("%0t: crc_match expected %b got %b", $time,
						want.crc_match, got.crc_match);
				end
				if (got.crc_plain !== want.crc_plain) begin
					err_count++;
					$display("%0t: crc_plain expected %h got %h", $time,
						want.crc_plain, got.crc_plain);
				end
				if (got.crc_reflected !== want.crc_reflected) begin
					err_count++;
					$display("%0t: crc_reflected expected %h got %h", $time,
						want.crc_reflected, got.crc_reflected);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("dual_crc16_check test failed");
			$finish;
		end
	end

	// stimulus
	initial begin
		logic [7:0]  msg[$];
		logic [15:0] p;
		logic [15:0] r;
		logic [15:0] chk;
		int          len;
		int          sel;
		int          i;
		int          rand_msgs;
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		plain_acc     = dcrc_pkg::CRC_INIT;
		refl_acc      = dcrc_pkg::CRC_INIT;
		err_count     = 0;
		cycle_count   = 0;
		results_seen  = 0;
		matches_seen  = 0;
		msgs_sent     = 0;
		bytes_sent    = 0;
		quiet         = 1'b0;
		hold_req      = 1'b0;
		rand_msgs     = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// directed table
		for (i = 0; i < 18; i++) begin
			send_item(dir_rows[i].data, dir_rows[i].last, dir_rows[i].chk,
				dir_rows[i].typed, dir_rows[i].res);
		end

		// random messages, mostly short, reference hitting either CRC, a near miss or noise
		while (bytes_sent < RANDOM_BYTES) begin
			sel = $urandom_range(0, 99);
			len = (sel < 80) ? $urandom_range(1, 8) :
			      (sel < 95) ? $urandom_range(9, 32) : $urandom_range(33, 96);
			msg.delete();
			p = dcrc_pkg::CRC_INIT;
			r = dcrc_pkg::CRC_INIT;
			for (i = 0; i < len; i++) begin
				msg.push_back(8'($urandom_range(0, 255)));
				p = crc_step(p, msg[i]);
				r = crc_step(r, flip_low({8'h00, msg[i]}, 8));
			end
			case ($urandom_range(0, 3))
				0: chk = p;
				1: chk = flip_low(r, 16);
				2: chk = 16'($urandom_range(0, 65535));
				default: chk = p ^ (16'h0001 << $urandom_range(0, 15));
			endcase
			if (rand_msgs == 15) begin
				hold_req = 1'b1;
			end
			if (bytes_sent >= QUIET_FROM) begin
				quiet = 1'b1;
			end
			for (i = 0; i < len; i++) begin
				send_item(msg[i], i == len - 1,
					(i == len - 1) ? chk : 16'($urandom_range(0, 65535)), 1'b0, '0);
			end
			rand_msgs++;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b0;

		// drain
		while (owed_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d bytes in %0d messages; checked %0d results, %0d of them matching.",
			bytes_sent, msgs_sent, results_seen, matches_seen);
		$display("Covered directed extremes, the standard check string and a long output stall.");
		if (err_count == 0) begin
			$display("dual_crc16_check test passed");
		end else begin
			$display("dual_crc16_check test failed");
		end
		$finish;
	end

endmodule
